### sv/tilemap_background_pixel_renderer_assert.svh
// ----------------------------------------------------------------------------
// Tilemap background renderer assertion macros
// Concurrent check helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_BACKGROUND_PIXEL_RENDERER_ASSERT_SVH
`define TILEMAP_BACKGROUND_PIXEL_RENDERER_ASSERT_SVH

// ante implies cons, sampled on the rising clock, off while reset is low
`define TBPR_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbpr check failed");

// expr never holds
`define TBPR_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tbpr check failed");

`endif

### sv/tbpr_pkg.sv
// ----------------------------------------------------------------------------
// Tilemap background renderer package
// Types, store sizes, codes and helper functions of the renderer.
// ----------------------------------------------------------------------------
package tbpr_pkg;

    localparam int MAP_ENTRIES     = 16384;
    localparam int TILE_BYTES      = 65536;
    localparam int PALETTE_ENTRIES = 256;

    localparam int MAP_AW  = $clog2(MAP_ENTRIES);
    localparam int TILE_AW = $clog2(TILE_BYTES);
    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

    localparam int MI_W       = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [15:0] ENT_TILE  = 16'h03FF;
    localparam logic [15:0] ENT_HFLIP = 16'h0400;
    localparam logic [15:0] ENT_VFLIP = 16'h0800;
    localparam logic [15:0] ENT_PAL   = 16'hF000;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SIZE = 1'b1;

    localparam logic [2:0] SCR_128     = 3'd0;
    localparam logic [2:0] SCR_256X512 = 3'd2;
    localparam logic [2:0] SCR_512X256 = 3'd3;
    localparam logic [2:0] SCR_512     = 3'd4;
    localparam logic [2:0] SCR_1024    = 3'd5;

    typedef enum logic [1:0] {
        OP_MAP_WR  = 2'd0,
        OP_TILE_WR = 2'd1,
        OP_PAL_WR  = 2'd2,
        OP_RENDER  = 2'd3
    } t_op;

    typedef enum logic {
        CLR_SWEEP,
        CLR_DONE
    } t_clr_state;

    typedef struct packed {
        t_op         opcode;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
    } t_req;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic        outside;
    } t_result;

    // request as it moves down the pipeline
    typedef struct packed {
        logic            vld;
        t_op             op;
        logic [15:0]     addr;
        logic [15:0]     data;
        logic [2:0]      x_lo;
        logic [2:0]      y_lo;
        logic            outside;
        logic            rd_ok;
        logic [MI_W-1:0] mi;
        logic [3:0]      pal;
        logic            nib_hi;
        logic            ci_zero;
    } t_item;

    function automatic logic [10:0] scr_width(input logic [2:0] sz);
        logic [10:0] w;
        unique case (sz)
            SCR_128:     w = 11'd128;
            SCR_256X512: w = 11'd256;
            SCR_512X256: w = 11'd512;
            SCR_512:     w = 11'd512;
            SCR_1024:    w = 11'd1024;
            default:     w = 11'd256;
        endcase
        return w;
    endfunction

    function automatic logic [10:0] scr_height(input logic [2:0] sz);
        logic [10:0] h;
        unique case (sz)
            SCR_128:     h = 11'd128;
            SCR_256X512: h = 11'd512;
            SCR_512X256: h = 11'd256;
            SCR_512:     h = 11'd512;
            SCR_1024:    h = 11'd1024;
            default:     h = 11'd256;
        endcase
        return h;
    endfunction

    // log2 of map entries per tile row
    function automatic logic [2:0] scr_row_shift(input logic [2:0] sz);
        logic [2:0] s;
        unique case (sz)
            SCR_128:     s = 3'd4;
            SCR_256X512: s = 3'd5;
            SCR_512X256: s = 3'd6;
            SCR_512:     s = 3'd6;
            SCR_1024:    s = 3'd7;
            default:     s = 3'd5;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

### sv/tilemap_background_pixel_renderer.sv
// ----------------------------------------------------------------------------
// Tilemap background pixel renderer
// One background layer: map, tile pattern and palette stores filled by write
// requests; render requests return one ABGR pixel each.
//
//   port group         direction  handshake
//   i_start/i_req      in         taken when i_start && !o_busy
//   o_valid/o_result   out        one-cycle strobe, receiver cannot stall
//   i_cfg_*            in         write when i_cfg_we, no wait
//
// One request per clock while o_busy is low. A render result strobes once its
// request has passed the request, map read, tile read, palette read and output
// registers. After reset the map store is swept to zero, one entry a clock,
// for all MAP_ENTRIES (16384) entries with o_busy high; config writes still
// apply. Reset is synchronous, active low. Nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module tilemap_background_pixel_renderer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  tbpr_pkg::t_req                      i_req,
    output logic                                o_busy,
    output logic                                o_valid,
    output tbpr_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [tbpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic             r_color_mode;
    logic [2:0]       r_screen_size;
    tbpr_pkg::t_item  s2_item;
    logic [15:0]      s2_ent;
    tbpr_pkg::t_item  s3_item;
    logic [7:0]       s3_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode  <= 1'b0;
            r_screen_size <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbpr_pkg::CFG_COLOR_MODE:  r_color_mode  <= i_cfg_data[0];
                tbpr_pkg::CFG_SCREEN_SIZE: r_screen_size <= i_cfg_data[2:0];
                default:                   r_color_mode  <= r_color_mode;
            endcase
        end
    end

    tbpr_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_req         (i_req),
        .i_screen_size (r_screen_size),
        .o_busy        (o_busy),
        .o_item        (s2_item),
        .o_ent         (s2_ent)
    );

    tbpr_tile u_tile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (s2_item),
        .i_ent        (s2_ent),
        .i_color_mode (r_color_mode),
        .o_item       (s3_item),
        .o_byte       (s3_byte)
    );

    tbpr_color u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (s3_item),
        .i_byte       (s3_byte),
        .i_color_mode (r_color_mode),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

endmodule

### sv/tbpr_map.sv
// ----------------------------------------------------------------------------
// Tilemap background renderer map stage
// Registers the request, locates the map entry and reads or writes the map
// store; sweeps the map to zero after reset.
// ----------------------------------------------------------------------------
module tbpr_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tbpr_pkg::t_req      i_req,
    input  logic [2:0]          i_screen_size,
    output logic                o_busy,
    output tbpr_pkg::t_item     o_item,
    output logic [15:0]         o_ent
);

    localparam int MAW = tbpr_pkg::MAP_AW;
    localparam int MIW = tbpr_pkg::MI_W;

    logic [15:0]           r_map_mem [tbpr_pkg::MAP_ENTRIES];
    logic [15:0]           r_map_q;
    tbpr_pkg::t_item       r_s1;
    tbpr_pkg::t_item       n_s1;
    tbpr_pkg::t_item       r_s2;
    tbpr_pkg::t_clr_state  r_clr_state;
    tbpr_pkg::t_clr_state  n_clr_state;
    logic [MAW-1:0]        r_clr_addr;
    logic [MAW-1:0]        n_clr_addr;
    logic                  clr_we;
    logic                  map_we;
    logic                  map_re;
    logic [10:0]           scr_w;
    logic [10:0]           scr_h;
    logic [2:0]            row_sh;
    logic [MIW-1:0]        mi;
    logic                  outside;

    always_comb begin
        scr_w   = tbpr_pkg::scr_width(i_screen_size);
        scr_h   = tbpr_pkg::scr_height(i_screen_size);
        row_sh  = tbpr_pkg::scr_row_shift(i_screen_size);
        outside = ({1'b0, i_req.pixel_x} >= scr_w) || ({1'b0, i_req.pixel_y} >= scr_h);
        mi      = (MIW'(i_req.pixel_y[9:3]) << row_sh) + MIW'(i_req.pixel_x[9:3]);

        n_s1         = '0;
        n_s1.vld     = i_start && !o_busy;
        n_s1.op      = i_req.opcode;
        n_s1.addr    = i_req.address;
        n_s1.data    = i_req.write_data;
        n_s1.x_lo    = i_req.pixel_x[2:0];
        n_s1.y_lo    = i_req.pixel_y[2:0];
        n_s1.outside = (i_req.opcode == tbpr_pkg::OP_RENDER) && outside;
        n_s1.mi      = mi;
        n_s1.rd_ok   = (i_req.opcode == tbpr_pkg::OP_RENDER) && !outside
                       && ({1'b0, mi} < (MIW+1)'(tbpr_pkg::MAP_ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
        end
    end

    // reset sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_state <= tbpr_pkg::CLR_SWEEP;
            r_clr_addr  <= '0;
        end else begin
            r_clr_state <= n_clr_state;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_comb begin
        n_clr_state = r_clr_state;
        n_clr_addr  = r_clr_addr;
        clr_we      = 1'b0;
        unique case (r_clr_state)
            tbpr_pkg::CLR_SWEEP: begin
                clr_we     = 1'b1;
                n_clr_addr = r_clr_addr + MAW'(1);
                if (r_clr_addr == MAW'(tbpr_pkg::MAP_ENTRIES - 1)) begin
                    n_clr_state = tbpr_pkg::CLR_DONE;
                end
            end
            tbpr_pkg::CLR_DONE: begin
                clr_we = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_clr_state == tbpr_pkg::CLR_SWEEP);

    assign map_we = r_s1.vld && (r_s1.op == tbpr_pkg::OP_MAP_WR)
                    && ({1'b0, r_s1.addr} < 17'(tbpr_pkg::MAP_ENTRIES));
    assign map_re = r_s1.vld && r_s1.rd_ok;

    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_map_mem[r_clr_addr] <= '0;
        end else if (map_we) begin
            r_map_mem[r_s1.addr[MAW-1:0]] <= r_s1.data;
        end
        if (map_re) begin
            r_map_q <= r_map_mem[r_s1.mi[MAW-1:0]];
        end
    end

    assign o_item = r_s2;
    assign o_ent  = r_s2.rd_ok ? r_map_q : 16'd0;

endmodule

### sv/tbpr_tile.sv
// ----------------------------------------------------------------------------
// Tilemap background renderer tile stage
// Applies flips, forms the pattern byte address and reads or writes the
// tile store.
// ----------------------------------------------------------------------------
module tbpr_tile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbpr_pkg::t_item  i_item,
    input  logic [15:0]      i_ent,
    input  logic             i_color_mode,
    output tbpr_pkg::t_item  o_item,
    output logic [7:0]       o_byte
);

    localparam int TAW = tbpr_pkg::TILE_AW;

    logic [7:0]       r_tile_mem [tbpr_pkg::TILE_BYTES];
    logic [7:0]       r_tile_q;
    tbpr_pkg::t_item  r_s3;
    tbpr_pkg::t_item  n_s3;
    logic [9:0]       tile;
    logic [2:0]       sx;
    logic [2:0]       sy;
    logic [15:0]      taddr;
    logic             t_ok;
    logic             tile_we;

    always_comb begin
        tile  = i_ent[9:0] & tbpr_pkg::ENT_TILE[9:0];
        sx    = |(i_ent & tbpr_pkg::ENT_HFLIP) ? ~i_item.x_lo : i_item.x_lo;
        sy    = |(i_ent & tbpr_pkg::ENT_VFLIP) ? ~i_item.y_lo : i_item.y_lo;
        taddr = i_color_mode ? {tile, sy, sx} : {1'b0, tile, sy, sx[2:1]};
        t_ok  = {1'b0, taddr} < 17'(tbpr_pkg::TILE_BYTES);

        n_s3        = i_item;
        n_s3.pal    = 4'((i_ent & tbpr_pkg::ENT_PAL) >> 12);
        n_s3.nib_hi = sx[0];
        n_s3.rd_ok  = (i_item.op == tbpr_pkg::OP_RENDER) && !i_item.outside && t_ok;
    end

    assign tile_we = i_item.vld && (i_item.op == tbpr_pkg::OP_TILE_WR)
                     && ({1'b0, i_item.addr} < 17'(tbpr_pkg::TILE_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tile_we) begin
            r_tile_mem[i_item.addr[TAW-1:0]] <= i_item.data[7:0];
        end
        if (i_item.vld && n_s3.rd_ok) begin
            r_tile_q <= r_tile_mem[taddr[TAW-1:0]];
        end
    end

    assign o_item = r_s3;
    assign o_byte = r_s3.rd_ok ? r_tile_q : 8'd0;

endmodule

### sv/tbpr_color.sv
// ----------------------------------------------------------------------------
// Tilemap background renderer color stage
// Forms the color index, reads or writes the palette and packs the ABGR
// result into the output register.
// ----------------------------------------------------------------------------
module tbpr_color (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbpr_pkg::t_item    i_item,
    input  logic [7:0]         i_byte,
    input  logic               i_color_mode,
    output logic               o_valid,
    output tbpr_pkg::t_result  o_result
);

    localparam int PAW = tbpr_pkg::PAL_AW;

    logic [15:0]                          r_pal_mem [tbpr_pkg::PALETTE_ENTRIES];
    logic [tbpr_pkg::PALETTE_ENTRIES-1:0] r_pal_wr;
    logic [15:0]                          r_pal_q;
    logic                                 r_pal_ok;
    tbpr_pkg::t_item                      r_s4;
    tbpr_pkg::t_item                      n_s4;
    logic                                 r_out_vld;
    tbpr_pkg::t_result                    r_out;
    logic [3:0]                           nib;
    logic [7:0]                           ci;
    logic                                 pal_we;
    logic [31:0]                          rgba;
    logic                                 visible;

    always_comb begin
        nib = i_item.nib_hi ? i_byte[7:4] : i_byte[3:0];
        if (i_color_mode) begin
            ci = i_byte;
        end else begin
            ci = (nib == 4'd0) ? 8'd0 : {i_item.pal, nib};
        end
        n_s4         = i_item;
        n_s4.ci_zero = (ci == 8'd0);
    end

    assign pal_we = i_item.vld && (i_item.op == tbpr_pkg::OP_PAL_WR)
                    && ({1'b0, i_item.addr} < 17'(tbpr_pkg::PALETTE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[i_item.addr[PAW-1:0]] <= i_item.data;
        end
        r_pal_q <= r_pal_mem[ci[PAW-1:0]];
    end

    // written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_wr <= '0;
        end else if (pal_we) begin
            r_pal_wr[i_item.addr[PAW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pal_ok <= r_pal_wr[ci[PAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else begin
            r_s4 <= n_s4;
        end
    end

    always_comb begin
        rgba = {8'hFF,
                tbpr_pkg::widen5(r_pal_q[14:10]),
                tbpr_pkg::widen5(r_pal_q[9:5]),
                tbpr_pkg::widen5(r_pal_q[4:0])};
        visible = !r_s4.outside && !r_s4.ci_zero && r_pal_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s4.vld && (r_s4.op == tbpr_pkg::OP_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.pixel_rgba <= visible ? rgba : 32'd0;
        r_out.outside    <= r_s4.outside;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

### sv/tbpr_checker.sv
// ----------------------------------------------------------------------------
// Tilemap background renderer checker
// Port-level checks on request timing and result encoding.
// ----------------------------------------------------------------------------
`include "tilemap_background_pixel_renderer_assert.svh"

module tbpr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input tbpr_pkg::t_req     i_req,
    input logic               o_busy,
    input logic               o_valid,
    input tbpr_pkg::t_result  o_result
);

    logic render_taken;
    logic outside_hit;
    logic lit_pixel;

    assign render_taken = i_start && !o_busy && (i_req.opcode == tbpr_pkg::OP_RENDER);
    assign outside_hit  = o_valid && o_result.outside;
    assign lit_pixel    = o_valid && (o_result.pixel_rgba != 32'd0);

    `TBPR_ASSERT(a_render_result, i_clk, i_rst_n, render_taken, ##5 o_valid)
    `TBPR_ASSERT(a_result_source, i_clk, i_rst_n, o_valid, $past(render_taken, 5))
    `TBPR_NEVER(a_busy_quiet, i_clk, i_rst_n, o_busy && o_valid)
    `TBPR_ASSERT(a_outside_zero, i_clk, i_rst_n, outside_hit, o_result.pixel_rgba == 32'd0)
    `TBPR_ASSERT(a_alpha_full, i_clk, i_rst_n, lit_pixel, o_result.pixel_rgba[31:24] == 8'hFF)

endmodule

bind tilemap_background_pixel_renderer tbpr_checker u_tbpr_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// Tilemap background pixel renderer testbench
// Drives map, tile and palette writes and pixel render requests through the
// start/busy port in random bursts, with register writes between phases, and
// checks every pixel strobe against a cycle-free model of the layer.
// ----------------------------------------------------------------------------
module tb;
    import tbpr_pkg::*;

    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES      = 10;
    localparam int SETTLE_CYCLES   = 8;

    localparam bit         PH_MODE [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    localparam logic [2:0] PH_SIZE [NUM_PHASES] = '{SCR_1024, SCR_128, SCR_256X512,
        SCR_512X256, SCR_512, 3'd6, 3'd7, SCR_1024, SCR_128, 3'd1};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_req                  i_req       = '0;
    logic                  o_busy;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    tilemap_background_pixel_renderer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // layer state as the block should hold it
    bit [15:0]   map_mem  [MAP_ENTRIES];
    bit [7:0]    tile_mem [TILE_BYTES];
    bit [15:0]   pal_mem  [PALETTE_ENTRIES];
    bit          pal_set  [PALETTE_ENTRIES];
    logic        cur_mode = 1'b0;
    logic [2:0]  cur_size = 3'd1;

    // request generation runs ahead of the block; it keeps its own map copy
    bit [15:0]   gen_map   [MAP_ENTRIES];
    bit          tile_seen [TILE_BYTES];
    int unsigned recent_tiles[$];

    t_req        req_q[$];
    t_result     pending_pixels[$];
    t_result     want;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_outside   = 0;
    int n_clear     = 0;
    int n_opaque    = 0;
    int errors      = 0;
    int burst_left  = 0;
    int idle_left   = 0;

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic logic [9:0] rand10();
        return 10'($urandom);
    endfunction

    function automatic void screen_dims(input logic [2:0] sz, output int unsigned w,
                                        output int unsigned h);
        case (sz)
            SCR_128:     begin w = 128;  h = 128;  end
            SCR_256X512: begin w = 256;  h = 512;  end
            SCR_512X256: begin w = 512;  h = 256;  end
            SCR_512:     begin w = 512;  h = 512;  end
            SCR_1024:    begin w = 1024; h = 1024; end
            default:     begin w = 256;  h = 256;  end
        endcase
    endfunction

    function automatic int unsigned map_index(input logic [9:0] x, input logic [9:0] y,
                                              input int unsigned w);
        return (y >> 3) * (w >> 3) + (x >> 3);
    endfunction

    function automatic int unsigned pattern_addr(input logic [15:0] ent, input logic [9:0] x,
                                                 input logic [9:0] y, input logic mode,
                                                 output logic nib_hi);
        int unsigned tile, sx, sy;
        tile = ent & ENT_TILE;
        sx = ((ent & ENT_HFLIP) != 0) ? 7 - x[2:0] : x[2:0];
        sy = ((ent & ENT_VFLIP) != 0) ? 7 - y[2:0] : y[2:0];
        nib_hi = sx[0];
        return mode ? tile * 64 + sy * 8 + sx : tile * 32 + sy * 4 + (sx >> 1);
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return 8'((c << 3) | (c >> 2));
    endfunction

    // apply one accepted request to the layer state, expect a pixel for renders
    task automatic track_request(input t_req rq);
        int unsigned w, h, a, ci;
        logic [15:0] ent, c;
        logic        hi;
        logic [7:0]  b;
        t_result     px;
        case (rq.opcode)
            OP_MAP_WR: begin
                if (rq.address < MAP_ENTRIES) map_mem[rq.address] = rq.write_data;
            end
            OP_TILE_WR: begin
                tile_mem[rq.address] = rq.write_data[7:0];
            end
            OP_PAL_WR: begin
                if (rq.address < PALETTE_ENTRIES) begin
                    pal_mem[rq.address] = rq.write_data;
                    pal_set[rq.address] = 1'b1;
                end
            end
            default: begin
                screen_dims(cur_size, w, h);
                px = '0;
                if (rq.pixel_x >= w || rq.pixel_y >= h) begin
                    px.outside = 1'b1;
                    n_outside++;
                end else begin
                    ent = map_mem[map_index(rq.pixel_x, rq.pixel_y, w)];
                    a = pattern_addr(ent, rq.pixel_x, rq.pixel_y, cur_mode, hi);
                    b = tile_mem[a];
                    if (cur_mode) begin
                        ci = b;
                    end else begin
                        ci = hi ? b[7:4] : b[3:0];
                        if (ci != 0) ci = ci + ((ent & ENT_PAL) >> 12) * 16;
                    end
                    if (ci != 0 && pal_set[ci]) begin
                        c = pal_mem[ci];
                        px.pixel_rgba = {8'hFF, expand5(c[14:10]), expand5(c[9:5]),
                                         expand5(c[4:0])};
                    end
                    if (px.pixel_rgba == 0) n_clear++;
                    else n_opaque++;
                end
                pending_pixels.push_back(px);
            end
        endcase
    endtask

    task automatic queue_request(input t_op op, input logic [15:0] addr,
                                 input logic [15:0] data, input logic [9:0] x,
                                 input logic [9:0] y);
        t_req rq;
        rq.opcode     = op;
        rq.address    = addr;
        rq.write_data = data;
        rq.pixel_x    = x;
        rq.pixel_y    = y;
        if (op == OP_MAP_WR && addr < MAP_ENTRIES) gen_map[addr] = data;
        if (op == OP_TILE_WR) tile_seen[addr] = 1'b1;
        req_q.push_back(rq);
        n_queued++;
    endtask

    // an on-screen pixel whose pattern byte was never written is preceded by a write of it
    task automatic queue_render(input logic [9:0] x, input logic [9:0] y);
        int unsigned w, h, a;
        logic        hi;
        logic [15:0] d;
        screen_dims(cur_size, w, h);
        if (x < w && y < h) begin
            a = pattern_addr(gen_map[map_index(x, y, w)], x, y, cur_mode, hi);
            if (!tile_seen[a]) begin
                d = rand16();
                if ($urandom_range(0, 99) < 15) d[7:0] = 8'h00;
                queue_request(OP_TILE_WR, 16'(a), d, rand10(), rand10());
            end
        end
        queue_request(OP_RENDER, rand16(), rand16(), x, y);
    endtask

    task automatic queue_random_item();
        int unsigned w, h, cols, r, mi;
        logic [9:0]  x, y;
        screen_dims(cur_size, w, h);
        cols = w / 8;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            if (recent_tiles.size() != 0 && $urandom_range(0, 99) < 60) begin
                mi = recent_tiles[$urandom_range(0, recent_tiles.size() - 1)];
                x = 10'((mi % cols) * 8 + $urandom_range(0, 7));
                y = 10'((mi / cols) * 8 + $urandom_range(0, 7));
            end else if ($urandom_range(0, 99) < 75) begin
                x = 10'($urandom_range(0, w - 1));
                y = 10'($urandom_range(0, h - 1));
            end else begin
                x = rand10();
                y = rand10();
            end
            queue_render(x, y);
        end else if (r < 55) begin
            if ($urandom_range(0, 9) < 8) begin
                mi = $urandom_range(0, h / 8 - 1) * cols + $urandom_range(0, cols - 1);
                recent_tiles.push_back(mi);
                if (recent_tiles.size() > 8) void'(recent_tiles.pop_front());
                queue_request(OP_MAP_WR, 16'(mi), rand16(), rand10(), rand10());
            end else begin
                queue_request(OP_MAP_WR, rand16(), rand16(), rand10(), rand10());
            end
        end else if (r < 72) begin
            queue_request(OP_TILE_WR, rand16(), rand16(), rand10(), rand10());
        end else if (r < 90) begin
            if ($urandom_range(0, 9) < 9)
                queue_request(OP_PAL_WR, 16'($urandom_range(0, 255)), rand16(), rand10(),
                              rand10());
            else
                queue_request(OP_PAL_WR, rand16(), rand16(), rand10(), rand10());
        end else begin
            queue_render(rand10(), rand10());
        end
    endtask

    task automatic drain();
        while (n_accepted != n_queued || pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_COLOR_MODE) cur_mode = val[0];
        else cur_size = val;
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                track_request(i_req);
                n_accepted++;
            end
            if (!i_start || !o_busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_start <= 1'b0;
                end else if (req_q.size() > 0) begin
                    i_req   <= req_q.pop_front();
                    i_start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        r_gap: begin
                            int unsigned g;
                            g = $urandom_range(0, 9);
                            idle_left = g < 4 ? 0 : g < 8 ? $urandom_range(1, 4)
                                                          : $urandom_range(5, 30);
                        end
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual rgba %h outside %b",
                         $time, o_result.pixel_rgba, o_result.outside);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_result.pixel_rgba !== want.pixel_rgba) begin
                    $display("%0t: pixel_rgba mismatch: expected %h, actual %h",
                             $time, want.pixel_rgba, o_result.pixel_rgba);
                    errors++;
                end
                if (o_result.outside !== want.outside) begin
                    $display("%0t: outside mismatch: expected %b, actual %b",
                             $time, want.outside, o_result.outside);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    initial begin
        #4000000;
        $display("tilemap_background_pixel_renderer regression: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 4bpp, 256x256
        queue_request(OP_PAL_WR, 16'h0011, 16'h7FFF, rand10(), rand10());
        queue_request(OP_PAL_WR, 16'h0012, 16'h8000, rand10(), rand10());
        queue_request(OP_PAL_WR, 16'hFFFF, 16'h7FFF, rand10(), rand10());
        queue_request(OP_PAL_WR, 16'h00FF, 16'h7C00, rand10(), rand10());
        queue_request(OP_MAP_WR, 16'h0000, 16'h1001, rand10(), rand10());
        queue_request(OP_MAP_WR, 16'h0001, 16'hFFFF, rand10(), rand10());
        queue_request(OP_MAP_WR, 16'hFFFF, 16'h0005, rand10(), rand10());
        queue_request(OP_MAP_WR, 16'h3FFF, 16'h03FF, rand10(), rand10());
        queue_request(OP_TILE_WR, 16'd32, 16'hAA21, rand10(), rand10());
        queue_request(OP_TILE_WR, 16'd33, 16'h5500, rand10(), rand10());
        queue_request(OP_TILE_WR, 16'd32767, 16'h00F0, rand10(), rand10());
        queue_render(10'd0, 10'd0);
        queue_render(10'd1, 10'd0);
        queue_render(10'd2, 10'd0);
        queue_render(10'd8, 10'd0);
        queue_render(10'd4, 10'd0);
        queue_render(10'd255, 10'd255);
        queue_render(10'd256, 10'd0);
        queue_render(10'd0, 10'd256);
        queue_render(10'd1023, 10'd1023);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(CFG_COLOR_MODE, {2'($urandom), PH_MODE[p]});
            write_cfg(CFG_SCREEN_SIZE, PH_SIZE[p]);
            recent_tiles.delete();
            for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_random_item();
            drain();
        end

        $display("%0d requests over %0d register settings; %0d pixels checked",
                 n_accepted, NUM_PHASES + 1, n_checked);
        $display("pixels: %0d opaque, %0d transparent or unset, %0d outside the screen",
                 n_opaque, n_clear, n_outside);
        if (errors == 0)
            $display("tilemap_background_pixel_renderer regression: pass");
        else
            $display("tilemap_background_pixel_renderer regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/tbpr_pkg.sv
sv/tbpr_map.sv
sv/tbpr_tile.sv
sv/tbpr_color.sv
sv/tilemap_background_pixel_renderer.sv
sv/tbpr_checker.sv
test/tb.sv
